/* design/mcg_pkg.sv */
// Shared types, constants and the sine series for the metronome click generator.
`timescale 1ns / 1ps
package mcg_pkg;

   localparam int POSITION_BITS_DEF = 48;
   localparam int SINE_ENTRIES_DEF = 1024;

   localparam logic [31:0] BEAT_RATE_RST = 32'd178957;
   localparam logic [4:0] BPB_RST = 5'd4;
   localparam logic [15:0] VOLUME_RST = 16'd32768;
   localparam logic [15:0] CLICK_LEN_RST = 16'd960;
   localparam logic [23:0] ENV_STEP_RST = 24'd17476;
   localparam logic [31:0] DOWN_STEP_RST = 32'd89478485;
   localparam logic [31:0] OFF_STEP_RST = 32'd71582788;

   localparam logic [15:0] COUNTER_DONE = 16'hFFFF;
   localparam logic [31:0] DOWNBEAT_BOOST = 32'd21299;
   localparam logic [5:0] BOOST_BITS = 6'd15;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q30_ONE = 64'd1 << 30;

   typedef enum logic [2:0] {
      REG_ENABLE     = 3'd0,
      REG_BEAT_RATE  = 3'd1,
      REG_BPB        = 3'd2,
      REG_VOLUME     = 3'd3,
      REG_CLICK_LEN  = 3'd4,
      REG_ENV_STEP   = 3'd5,
      REG_DOWN_STEP  = 3'd6,
      REG_OFF_STEP   = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE, S_BEAT, S_ENV, S_E2, S_VOL, S_BOOST, S_SIN, S_OUT
   } state_type;

   typedef struct packed {
      logic       start;
      logic [5:0] len;
   } mul_ctrl_type;

   // sin(pi/2 * r / 2^lg) in Q30
   function automatic logic [63:0] quarter_sine(input logic [63:0] r, input int lg);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      x = (r * HALF_PI_Q30) >> lg;
      x2 = (x * x) >> 30;
      t = Q30_ONE - x2 / 64'd110;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      return (x * t) >> 30;
   endfunction

endpackage

/* design/mcg_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module mcg_mul import mcg_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  mul_ctrl_type ctrl,
   input  logic [31:0]  a,
   input  logic [31:0]  b,
   output logic         done,
   output logic [63:0]  product
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in = ctrl.len;
         a_in = a;
         b_in = b << (6'd32 - ctrl.len);
         acc_in = '0;
      end else if (busy_ff) begin
         acc_in = {acc_ff[62:0], 1'b0} + (b_ff[31] ? {32'd0, a_ff} : 64'd0);
         b_in = {b_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

/* design/mcg_beat.sv */
// Serial beat index (signed position times rate) and bit-serial beat-in-bar remainder.
`timescale 1ns / 1ps
module mcg_beat import mcg_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [POSITION_BITS-1:0] position,
   input  logic [31:0]                     beat_rate,
   input  logic [4:0]                      beats_per_bar,
   output logic                            done,
   output logic signed [POSITION_BITS-1:0] beat_index,
   output logic                            downbeat
);

   localparam int CW = $clog2(POSITION_BITS + 1);

   logic                          mul_ff, mul_in;
   logic                          div_ff, div_in;
   logic                          done_ff, done_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic signed [POSITION_BITS:0] acc_ff, acc_in;
   logic signed [POSITION_BITS:0] sum;
   logic [31:0]                   rate_ff, rate_in;
   logic [POSITION_BITS-1:0]      num_ff, num_in;
   logic [4:0]                    rem_ff, rem_in;
   logic [4:0]                    div_d;
   logic [5:0]                    trial;

   assign div_d = (beats_per_bar == 5'd0) ? 5'd1 : beats_per_bar;
   assign sum = acc_ff + (rate_ff[0] ? {position[POSITION_BITS-1], position}
                                      : {(POSITION_BITS+1){1'b0}});
   assign trial = {rem_ff, num_ff[POSITION_BITS-1]};

   always_comb begin
      mul_in = mul_ff;
      div_in = div_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      rate_in = rate_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      if (start) begin
         mul_in = 1'b1;
         cnt_in = CW'(32);
         acc_in = '0;
         rate_in = beat_rate;
      end else if (mul_ff) begin
         acc_in = sum >>> 1;
         rate_in = {1'b0, rate_ff[31:1]};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            mul_in = 1'b0;
            div_in = 1'b1;
            cnt_in = CW'(POSITION_BITS);
            num_in = acc_in[POSITION_BITS-1:0];
            rem_in = '0;
         end
      end else if (div_ff) begin
         num_in = {num_ff[POSITION_BITS-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_d}) ? 5'(trial - {1'b0, div_d}) : trial[4:0];
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            div_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff <= 1'b0;
         div_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         mul_ff <= mul_in;
         div_ff <= div_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rate_ff <= rate_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign beat_index = acc_ff[POSITION_BITS-1:0];
   assign downbeat = (rem_ff == 5'd0);

endmodule

/* design/mcg_sine_rom.sv */
// Sine table ROM in Q1.15 with registered read data.
`timescale 1ns / 1ps
module mcg_sine_rom import mcg_pkg::*; #(
   parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
   input  logic                                  clock,
   input  logic [$clog2(SINE_TABLE_ENTRIES)-1:0] addr,
   output logic signed [15:0]                    rd_data
);

   localparam int LG = $clog2(SINE_TABLE_ENTRIES);

   typedef logic signed [15:0] rom_type [SINE_TABLE_ENTRIES];

   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] n;
      logic [63:0] k;
      logic [63:0] r;
      logic [63:0] s;
      logic [63:0] v;
      for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
         n = 64'(i) * 64'd4;
         k = n >> LG;
         r = n & 64'(SINE_TABLE_ENTRIES - 1);
         s = k[0] ? quarter_sine(64'(SINE_TABLE_ENTRIES) - r, LG) : quarter_sine(r, LG);
         v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
         rom[i] = k[1] ? -16'(v) : 16'(v);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic signed [15:0] rd_ff;

   always_ff @(posedge clock) begin
      rd_ff <= SINE_ROM[addr];
   end

   assign rd_data = rd_ff;

endmodule

/* design/metronome_click_generator_unit.sv */
// Top level of the metronome click generator: registers, sequencer and click state.
`timescale 1ns / 1ps
// Usage:
//   req_ channel: one transaction per audio sample; req_tdata carries the
//   transport position, req_tuser the playing flag. rsp_ channel: one
//   transaction per request, the Q2.14 click sample in rsp_tdata and the
//   downbeat flag in rsp_tuser. csr_ writes go in whenever csr_we is high;
//   write only while no request is in flight.
//   Flow: a silent request (disabled or stopped) goes from acceptance
//   through S_OUT into the output register, and the next request can go
//   in once the sequencer is back in S_IDLE. A played request runs the
//   bit-serial beat multiply and remainder, then, if a click sounds, up
//   to five serial multiplies on one shared shift-add unit (envelope,
//   envelope square, volume, downbeat boost on a downbeat click only,
//   sine); when no click sounds it goes from the beat unit to S_OUT.
//   One request is worked at a time; the next is taken only in S_IDLE.
//   The next request is taken as soon as the result sits in the output
//   register, even if the receiver has not yet taken it.
//   Stall: the result holds in rsp_tdata/rsp_tuser until rsp_tready.
//   Reset: registers return to their defaults, no click sounds, beat index
//   and phase clear; the sine table is a constant ROM, no fill pass.
module metronome_click_generator_unit import mcg_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int SINE_TABLE_ENTRIES = SINE_ENTRIES_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((POSITION_BITS + 7) / 8) * 8-1:0] req_tdata,  // position
   input  logic                                     req_tuser,  // playing
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [15:0]                              rsp_tdata,  // sample
   output logic                                     rsp_tuser,  // downbeat_click
   input  logic                                     csr_we,
   input  logic [2:0]                               csr_index,
   input  logic [31:0]                              csr_wdata
);

   localparam int LG = $clog2(SINE_TABLE_ENTRIES);

   // configuration
   logic        enable_ff;
   logic [31:0] beat_rate_ff;
   logic [4:0]  bpb_ff;
   logic [15:0] volume_ff;
   logic [15:0] click_len_ff;
   logic [23:0] env_step_ff;
   logic [31:0] down_step_ff;
   logic [31:0] off_step_ff;

   // click state
   state_type                     state_ff, state_in;
   logic                          launch_ff;
   logic signed [POSITION_BITS-1:0] pos_ff, pos_in;
   logic signed [POSITION_BITS-1:0] last_ff, last_in;
   logic [15:0]                   counter_ff, counter_in;
   logic [31:0]                   phase_ff, phase_in;
   logic                          flag_ff, flag_in;
   logic [24:0]                   e_ff, e_in;
   logic [16:0]                   g_ff, g_in;
   logic [15:0]                   smp_ff, smp_in;
   logic                          dbc_ff, dbc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_user_ff, rsp_user_in;

   // units
   logic                          beat_start;
   logic                          beat_done;
   logic signed [POSITION_BITS-1:0] beat_idx;
   logic                          beat_down;
   mul_ctrl_type                  mul_ctrl;
   logic [31:0]                   mul_a, mul_b;
   logic                          mul_done;
   logic [63:0]                   mul_p;
   logic signed [15:0]            sine_v;
   logic [14:0]                   sine_mag;
   logic                          click_start;
   logic [15:0]                   counter_new;
   logic [15:0]                   counter_inc;
   logic [46:0]                   mag_wide;
   logic [14:0]                   mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         beat_rate_ff <= BEAT_RATE_RST;
         bpb_ff <= BPB_RST;
         volume_ff <= VOLUME_RST;
         click_len_ff <= CLICK_LEN_RST;
         env_step_ff <= ENV_STEP_RST;
         down_step_ff <= DOWN_STEP_RST;
         off_step_ff <= OFF_STEP_RST;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_ENABLE:    enable_ff <= csr_wdata[0];
            REG_BEAT_RATE: beat_rate_ff <= csr_wdata;
            REG_BPB:       bpb_ff <= csr_wdata[4:0];
            REG_VOLUME:    volume_ff <= csr_wdata[15:0];
            REG_CLICK_LEN: click_len_ff <= csr_wdata[15:0];
            REG_ENV_STEP:  env_step_ff <= csr_wdata[23:0];
            REG_DOWN_STEP: down_step_ff <= csr_wdata;
            REG_OFF_STEP:  off_step_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mcg_beat #(.POSITION_BITS(POSITION_BITS)) u_beat (
      .clock         (clock),
      .reset         (reset),
      .start         (beat_start),
      .position      (pos_ff),
      .beat_rate     (beat_rate_ff),
      .beats_per_bar (bpb_ff),
      .done          (beat_done),
      .beat_index    (beat_idx),
      .downbeat      (beat_down)
   );

   mcg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mul_ctrl),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   mcg_sine_rom #(.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)) u_rom (
      .clock   (clock),
      .addr    (phase_ff[31 -: LG]),
      .rd_data (sine_v)
   );

   assign sine_mag = sine_v[15] ? 15'(-sine_v) : sine_v[14:0];
   assign click_start = (beat_idx > last_ff) && !pos_ff[POSITION_BITS-1];
   assign counter_new = click_start ? 16'd0 : counter_ff;
   assign counter_inc = counter_ff + 16'd1;
   assign mag_wide = mul_p[63:17];
   assign mag = (mag_wide > 47'd32767) ? 15'h7FFF : mag_wide[14:0];

   assign req_tready = (state_ff == S_IDLE);
   assign beat_start = launch_ff && (state_ff == S_BEAT);

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      last_in = last_ff;
      counter_in = counter_ff;
      phase_in = phase_ff;
      flag_in = flag_ff;
      e_in = e_ff;
      g_in = g_ff;
      smp_in = smp_ff;
      dbc_in = dbc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      mul_ctrl.start = 1'b0;
      mul_ctrl.len = 6'd16;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pos_in = req_tdata[POSITION_BITS-1:0];
               smp_in = '0;
               dbc_in = 1'b0;
               state_in = (enable_ff && req_tuser) ? S_BEAT : S_OUT;
            end
         end
         S_BEAT: begin
            if (beat_done) begin
               last_in = beat_idx;
               if (click_start) begin
                  counter_in = 16'd0;
                  phase_in = '0;
                  flag_in = beat_down;
               end
               state_in = (counter_new >= click_len_ff) ? S_OUT : S_ENV;
            end
         end
         S_ENV: begin
            mul_ctrl.start = launch_ff;
            mul_ctrl.len = 6'd16;
            mul_a = {8'd0, env_step_ff};
            mul_b = {16'd0, counter_ff};
            if (mul_done && !launch_ff) begin
               e_in = (mul_p[39:24] != 16'd0) ? 25'd0 : 25'(26'h1000000 - mul_p[23:0]);
               state_in = S_E2;
            end
         end
         S_E2: begin
            mul_ctrl.start = launch_ff;
            mul_ctrl.len = 6'd25;
            mul_a = {7'd0, e_ff};
            mul_b = {7'd0, e_ff};
            if (mul_done && !launch_ff) begin
               g_in = mul_p[48:32];
               state_in = S_VOL;
            end
         end
         S_VOL: begin
            mul_ctrl.start = launch_ff;
            mul_ctrl.len = 6'd16;
            mul_a = {15'd0, g_ff};
            mul_b = {16'd0, volume_ff};
            if (mul_done && !launch_ff) begin
               g_in = mul_p[32:16];
               state_in = flag_ff ? S_BOOST : S_SIN;
            end
         end
         S_BOOST: begin
            mul_ctrl.start = launch_ff;
            mul_ctrl.len = BOOST_BITS;
            mul_a = {15'd0, g_ff};
            mul_b = DOWNBEAT_BOOST;
            if (mul_done && !launch_ff) begin
               g_in = mul_p[30:14];
               state_in = S_SIN;
            end
         end
         S_SIN: begin
            mul_ctrl.start = launch_ff;
            mul_ctrl.len = 6'd15;
            mul_a = {15'd0, g_ff};
            mul_b = {17'd0, sine_mag};
            if (mul_done && !launch_ff) begin
               smp_in = sine_v[15] ? -{1'b0, mag} : {1'b0, mag};
               dbc_in = flag_ff;
               phase_in = phase_ff + (flag_ff ? down_step_ff : off_step_ff);
               counter_in = (counter_inc >= click_len_ff) ? COUNTER_DONE : counter_inc;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = smp_ff;
               rsp_user_in = dbc_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         launch_ff <= 1'b0;
         last_ff <= '0;
         counter_ff <= COUNTER_DONE;
         phase_ff <= '0;
         flag_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         launch_ff <= (state_in != state_ff);
         last_ff <= last_in;
         counter_ff <= counter_in;
         phase_ff <= phase_in;
         flag_ff <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      e_ff <= e_in;
      g_ff <= g_in;
      smp_ff <= smp_in;
      dbc_ff <= dbc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule
